FILE: rtl/core/hpu_pkg.sv
// Shared definitions for the upward-pointing hull classifier.
// Holds default sizes and the command/status bundles between controller and datapath.
// No dependencies.
package hpu_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int COORD_BITS_DEF = 10;

  typedef struct packed {
    logic accept;      // store one vertex this cycle
    logic begin_eval;  // capture height and narrow verdict, clear pass state
    logic pass_run;    // walk the vertex store
    logic pass_sel;    // 0: lower span pass, 1: upper containment pass
    logic clr_idx;     // rewind the store walk
    logic emit;        // load the result register and clear the polygon
  } hpu_cmd_t;

  typedef struct packed {
    logic reject;      // overflow, empty or too wide
    logic pass_done;   // every stored vertex has been examined
    logic have_lower;  // at least one vertex at or below the center
    logic out_free;    // result register can take a new result
  } hpu_sts_t;

endpackage

FILE: rtl/core/hull_points_up_classifier_top.sv
// Top level of the upward-pointing hull classifier.
// Instantiates hpu_ctrl (sequencer) and hpu_dp (store, bounding box, passes).
// Depends on hpu_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one polygon vertex per transfer,
//   in_point_x, in_point_y, with in_last_point marking the final vertex.
//   Result channel (out_valid / out_stall): one transfer per polygon,
//   carrying out_points_up and out_overflow.
//   Vertices load at one per cycle. Once the last vertex is taken the
//   input stalls while the block evaluates: the width/height check, then
//   two walks of the vertex store (one read per cycle, then waiting for the
//   last read to land and for the walk to be seen done), then loading the
//   result register once the output slot is free. Early rejects skip the
//   remaining walks: too wide, empty or overflow skip both, and no lower
//   vertex skips the second walk.
//   The store read port sets the pace.
//   Vertices beyond MAX_POINTS are dropped and flag overflow.
//   A pending result stays in the output register while out_stall is high;
//   the next polygon may load meanwhile, and its result waits for the slot.
//   Synchronous reset (rst_n low) empties the polygon and drops any result.
module hull_points_up_classifier_top #(
  parameter int MAX_POINTS = hpu_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = hpu_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_point_x,
  input  logic [COORD_BITS-1:0] in_point_y,
  input  logic                  in_last_point,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_points_up,
  output logic                  out_overflow
);

  hpu_pkg::hpu_cmd_t cmd;
  hpu_pkg::hpu_sts_t sts;

  // Sequencer: owns the input handshake and steps through the passes.
  hpu_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_point (in_last_point),
    .in_stall      (in_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  // Datapath: holds the vertices and the result register.
  hpu_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_points_up (out_points_up),
    .out_overflow  (out_overflow)
  );

endmodule

FILE: rtl/core/hpu_ctrl.sv
// Controller state machine for the hull classifier.
// Sequences vertex loading, the narrow check, two store passes and result hand-off.
// Depends on hpu_pkg.
module hpu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_point,
  output logic              in_stall,
  input  hpu_pkg::hpu_sts_t sts,
  output hpu_pkg::hpu_cmd_t cmd
);

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_PASS1  = 3'd2;
  localparam logic [2:0] ST_PASS2  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_stall       = 1'b1;
    unique case (state_r)
      ST_LOAD: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && in_last_point) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.begin_eval = 1'b1;
        state_nxt      = sts.reject ? ST_FINISH : ST_PASS1;
      end
      ST_PASS1: begin
        cmd.pass_run = 1'b1;
        cmd.pass_sel = 1'b0;
        if (sts.pass_done) begin
          cmd.clr_idx = 1'b1;
          state_nxt   = sts.have_lower ? ST_PASS2 : ST_FINISH;
        end
      end
      ST_PASS2: begin
        cmd.pass_run = 1'b1;
        cmd.pass_sel = 1'b1;
        if (sts.pass_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/hpu_dp.sv
// Datapath for the hull classifier: vertex store, bounding box, pass logic, result register.
// Driven by hpu_ctrl through hpu_pkg command and status bundles.
// Depends on hpu_pkg.
module hpu_dp #(
  parameter int MAX_POINTS = hpu_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = hpu_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hpu_pkg::hpu_cmd_t     cmd,
  output hpu_pkg::hpu_sts_t     sts,
  input  logic [COORD_BITS-1:0] in_point_x,
  input  logic [COORD_BITS-1:0] in_point_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_points_up,
  output logic                  out_overflow
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int HW     = COORD_BITS + 1;
  localparam int MW     = COORD_BITS + 4;
  localparam int DW     = 2 * COORD_BITS;

  logic [DW-1:0] mem [MAX_POINTS];
  logic [DW-1:0] rdata_r;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [COORD_BITS-1:0] min_x_r, min_x_nxt, max_x_r, max_x_nxt;
  logic [COORD_BITS-1:0] min_y_r, min_y_nxt, max_y_r, max_y_nxt;
  logic                  too_many_r, too_many_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic                  rv_r, rv_nxt;
  logic                  have_lower_r, have_lower_nxt;
  logic                  fail_r, fail_nxt;
  logic [COORD_BITS-1:0] lo_x_r, lo_x_nxt, hi_x_r, hi_x_nxt;
  logic [HW-1:0]         hgt_r;
  logic                  narrow_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_points_up_r, out_overflow_r;

  logic                  store_ok;
  logic                  issue;
  logic [HW-1:0]         wid_now, hgt_now;
  logic [MW-1:0]         five_wid, four_hgt;
  logic                  narrow_now;
  logic [COORD_BITS-1:0] rd_x, rd_y, dy;
  logic                  is_lower;

  // Bounding box size and the 5*w < 4*h test.
  assign wid_now    = {1'b0, max_x_r} - {1'b0, min_x_r} + HW'(1);
  assign hgt_now    = {1'b0, max_y_r} - {1'b0, min_y_r} + HW'(1);
  assign five_wid   = ({3'b000, wid_now} << 2) + {3'b000, wid_now};
  assign four_hgt   = {3'b000, hgt_now} << 2;
  assign narrow_now = five_wid < four_hgt;

  assign store_ok = count_r < CNT_W'(MAX_POINTS);
  assign issue    = cmd.pass_run && (idx_r != count_r);

  assign rd_x     = rdata_r[DW-1:COORD_BITS];
  assign rd_y     = rdata_r[COORD_BITS-1:0];
  assign dy       = rd_y - min_y_r;
  assign is_lower = {dy, 1'b0} >= hgt_r;

  assign sts.reject     = too_many_r || (count_r == '0) || !narrow_now;
  assign sts.pass_done  = (idx_r == count_r) && !rv_r;
  assign sts.have_lower = have_lower_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    count_nxt      = count_r;
    min_x_nxt      = min_x_r;
    max_x_nxt      = max_x_r;
    min_y_nxt      = min_y_r;
    max_y_nxt      = max_y_r;
    too_many_nxt   = too_many_r;
    idx_nxt        = idx_r;
    rv_nxt         = 1'b0;
    have_lower_nxt = have_lower_r;
    fail_nxt       = fail_r;
    lo_x_nxt       = lo_x_r;
    hi_x_nxt       = hi_x_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (cmd.accept) begin
      if (store_ok) begin
        count_nxt = count_r + CNT_W'(1);
        if (in_point_x < min_x_r) min_x_nxt = in_point_x;
        if (in_point_x > max_x_r) max_x_nxt = in_point_x;
        if (in_point_y < min_y_r) min_y_nxt = in_point_y;
        if (in_point_y > max_y_r) max_y_nxt = in_point_y;
      end else begin
        too_many_nxt = 1'b1;
      end
    end

    // Walk the store: issue a read, consume it in the next cycle.
    if (issue) begin
      idx_nxt = idx_r + CNT_W'(1);
      rv_nxt  = 1'b1;
    end
    if (rv_r) begin
      if (!cmd.pass_sel) begin
        if (is_lower) begin
          if (!have_lower_r) begin
            lo_x_nxt       = rd_x;
            hi_x_nxt       = rd_x;
            have_lower_nxt = 1'b1;
          end else begin
            if (rd_x < lo_x_r) lo_x_nxt = rd_x;
            if (rd_x > hi_x_r) hi_x_nxt = rd_x;
          end
        end
      end else if (!is_lower && ((rd_x < lo_x_r) || (rd_x > hi_x_r))) begin
        fail_nxt = 1'b1;
      end
    end

    if (cmd.clr_idx || cmd.begin_eval) begin
      idx_nxt = '0;
      rv_nxt  = 1'b0;
    end
    if (cmd.begin_eval) begin
      have_lower_nxt = 1'b0;
      fail_nxt       = 1'b0;
    end

    // Hand off the result and clear the polygon.
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      count_nxt     = '0;
      min_x_nxt     = '1;
      max_x_nxt     = '0;
      min_y_nxt     = '1;
      max_y_nxt     = '0;
      too_many_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      min_x_r      <= '1;
      max_x_r      <= '0;
      min_y_r      <= '1;
      max_y_r      <= '0;
      too_many_r   <= 1'b0;
      idx_r        <= '0;
      rv_r         <= 1'b0;
      have_lower_r <= 1'b0;
      fail_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      min_x_r      <= min_x_nxt;
      max_x_r      <= max_x_nxt;
      min_y_r      <= min_y_nxt;
      max_y_r      <= max_y_nxt;
      too_many_r   <= too_many_nxt;
      idx_r        <= idx_nxt;
      rv_r         <= rv_nxt;
      have_lower_r <= have_lower_nxt;
      fail_r       <= fail_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_x_r <= lo_x_nxt;
    hi_x_r <= hi_x_nxt;
    if (cmd.begin_eval) begin
      hgt_r    <= hgt_now;
      narrow_r <= narrow_now;
    end
    if (cmd.emit) begin
      out_points_up_r <= !too_many_r && narrow_r && have_lower_r && !fail_r;
      out_overflow_r  <= too_many_r;
    end
  end

  // Vertex store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.accept && store_ok) begin
      mem[count_r[ADDR_W-1:0]] <= {in_point_x, in_point_y};
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_points_up = out_points_up_r;
  assign out_overflow  = out_overflow_r;

endmodule
